FILE: rtl/pcsd_pkg.sv
// Shared types, codes and rectangle helpers of the pixel command stream decoder.
package pcsd_pkg;

	localparam int POS_W       = 17;
	localparam int DIM_W       = 16;
	localparam int BUF_W       = 25;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		KIND_NONE   = 3'd0,
		KIND_WRITE  = 3'd1,
		KIND_READ   = 3'd2,
		KIND_INFO   = 3'd3,
		KIND_REFUSE = 3'd4
	} kind_t;

	localparam logic [7:0] OP_INFO    = 8'h49;
	localparam logic [7:0] OP_PIX_WR  = 8'h50;
	localparam logic [7:0] OP_PIX_RD  = 8'h47;
	localparam logic [7:0] OP_RECT_WR = 8'h70;
	localparam logic [7:0] OP_RECT_RD = 8'h67;

	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_W  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_H  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUF_BYTES = 2'd2;

	localparam logic [DIM_W-1:0] CANVAS_W_RST  = 16'd1920;
	localparam logic [DIM_W-1:0] CANVAS_H_RST  = 16'd1080;
	localparam logic [BUF_W-1:0] BUF_BYTES_RST = 25'd65536;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] xstart;
		logic [POS_W-1:0] xstop;
		logic [POS_W-1:0] ystop;
	} rect_t;

	typedef struct packed {
		kind_t            kind;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [23:0]      rgb;
		logic             busy;
	} res_t;

	function automatic logic rect_done(input rect_t r);
		return (r.y == r.ystop) || (r.xstart == r.xstop);
	endfunction

	function automatic rect_t rect_next(input rect_t r);
		rect_t n;
		n = r;
		if (!rect_done(r)) begin
			n.x = r.x + POS_W'(1);
			if (n.x == r.xstop) begin
				n.x = r.xstart;
				n.y = r.y + POS_W'(1);
			end
		end
		return n;
	endfunction

endpackage

FILE: rtl/pcsd_if.sv
// Stream interfaces for command items and result items.
interface pcsd_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;

	modport source (output valid, output func, output data_byte, input ready);
	modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface pcsd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [16:0] pos_x;
	logic [16:0] pos_y;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [24:0] reply_buffer_size;
	logic        busy_res;

	modport source (output valid, output kind, output pos_x, output pos_y, output red,
		output green, output blue, output reply_buffer_size, output busy_res, input ready);
	modport sink (input valid, input kind, input pos_x, input pos_y, input red,
		input green, input blue, input reply_buffer_size, input busy_res, output ready);
endinterface

FILE: rtl/pcsd_front.sv
// Front end: accepts items, assembles commands and walks the rectangles.
module pcsd_front
	import pcsd_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int SIZE_BITS  = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	pcsd_in_if.sink     cmd_in,
	input  logic        full,
	output logic        push,
	output res_t        push_res
);

	logic [7:0]  cmd_q [8];
	logic [2:0]  fill_q, fill_n;
	logic [1:0]  gf_q, gf_n;
	logic [23:0] color_q, color_n;
	rect_t       wr_q, wr_n, rd_q, rd_n;
	logic        held_q, held_n;
	logic        acc, emit, cmd_we;

	assign cmd_in.ready = !full;
	assign acc          = cmd_in.valid && cmd_in.ready;
	assign push         = acc && emit;

	always_comb begin
		logic [7:0]            cb [8];
		logic [15:0]           xy_x, xy_y;
		logic [11:0]           sz_w, sz_h;
		logic [COORD_BITS-1:0] cx, cy;
		logic [SIZE_BITS-1:0]  w, h;
		rect_t                 nr;
		logic                  exec_go, from_hold, rd_busy;

		fill_n   = fill_q;
		gf_n     = gf_q;
		color_n  = color_q;
		wr_n     = wr_q;
		rd_n     = rd_q;
		held_n   = held_q;
		cmd_we   = 1'b0;
		emit     = 1'b0;
		push_res = '0;
		exec_go  = 1'b0;
		from_hold = 1'b0;
		rd_busy  = !rect_done(rd_q);

		for (int i = 0; i < 7; i++) begin
			cb[i] = cmd_q[i];
		end
		cb[7] = cmd_in.func ? cmd_q[7] : cmd_in.data_byte;
		xy_x  = {cb[2], cb[1]};
		xy_y  = {cb[4], cb[3]};
		sz_w  = {cb[7][3:0], cb[5]};
		sz_h  = {cb[7][7:4], cb[6]};
		cx    = xy_x[COORD_BITS-1:0];
		cy    = xy_y[COORD_BITS-1:0];
		w     = sz_w[SIZE_BITS-1:0];
		h     = sz_h[SIZE_BITS-1:0];
		nr.xstart = POS_W'(cx);
		nr.x      = POS_W'(cx);
		nr.y      = POS_W'(cy);
		nr.xstop  = POS_W'(cx) + POS_W'(w);
		nr.ystop  = POS_W'(cy) + POS_W'(h);

		if (cmd_in.func) begin
			if (rd_busy) begin
				emit          = 1'b1;
				push_res.kind = KIND_READ;
				push_res.x    = rd_q.x;
				push_res.y    = rd_q.y;
				rd_n          = rect_next(rd_q);
			end else if (held_q) begin
				held_n    = 1'b0;
				exec_go   = 1'b1;
				from_hold = 1'b1;
			end
		end else if (held_q) begin
			emit          = 1'b1;
			push_res.kind = KIND_REFUSE;
		end else if (!rect_done(wr_q)) begin
			case (gf_q)
				2'd0: color_n[23:16] = cmd_in.data_byte;
				2'd1: color_n[15:8]  = cmd_in.data_byte;
				2'd2: color_n[7:0]   = cmd_in.data_byte;
				default: color_n     = color_q;
			endcase
			gf_n = gf_q + 2'd1;
			if (gf_q == 2'd3) begin
				emit          = 1'b1;
				push_res.kind = KIND_WRITE;
				push_res.x    = wr_q.x;
				push_res.y    = wr_q.y;
				push_res.rgb  = color_q;
				wr_n          = rect_next(wr_q);
			end
		end else begin
			cmd_we = 1'b1;
			fill_n = fill_q + 3'd1;
			exec_go = (fill_q == 3'd7);
		end

		if (exec_go) begin
			if ((cb[0] == OP_INFO || cb[0] == OP_PIX_RD || cb[0] == OP_RECT_RD) && rd_busy) begin
				held_n        = 1'b1;
				emit          = 1'b1;
				push_res.kind = KIND_NONE;
			end else begin
				case (cb[0])
					OP_INFO: begin
						emit          = 1'b1;
						push_res.kind = KIND_INFO;
					end
					OP_PIX_RD: begin
						emit          = 1'b1;
						push_res.kind = KIND_READ;
						push_res.x    = POS_W'(cx);
						push_res.y    = POS_W'(cy);
					end
					OP_PIX_WR: begin
						emit          = 1'b1;
						push_res.kind = KIND_WRITE;
						push_res.x    = POS_W'(cx);
						push_res.y    = POS_W'(cy);
						push_res.rgb  = {cb[5], cb[6], cb[7]};
					end
					OP_RECT_WR: begin
						wr_n = nr;
						gf_n = 2'd0;
					end
					OP_RECT_RD: begin
						rd_n          = nr;
						emit          = from_hold;
						push_res.kind = KIND_NONE;
					end
					default: emit = 1'b0;
				endcase
			end
		end
		push_res.busy = held_n;
	end

	always_ff @(posedge clk) begin
		if (acc && cmd_we) begin
			cmd_q[fill_q] <= cmd_in.data_byte;
		end
		if (acc) begin
			color_q <= color_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			gf_q   <= '0;
			wr_q   <= '0;
			rd_q   <= '0;
			held_q <= 1'b0;
		end else if (acc) begin
			fill_q <= fill_n;
			gf_q   <= gf_n;
			wr_q   <= wr_n;
			rd_q   <= rd_n;
			held_q <= held_n;
		end
	end

	a_held_only_on_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> fill_q == 3'd0)
		else $error("held command with partial command pending");

	a_group_inside_rect: assert property (@(posedge clk) disable iff (!arst_n)
		gf_q != 2'd0 |-> !rect_done(wr_q))
		else $error("colour group open without write rectangle");

	a_held_while_reading: assert property (@(posedge clk) disable iff (!arst_n)
		held_q && !rect_done(rd_q) |=> held_q)
		else $error("held command released while read rectangle open");

endmodule

FILE: rtl/pcsd_queue.sv
// Short result queue between front end and back end.
module pcsd_queue
	import pcsd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic full,
	input  logic pop,
	output res_t pop_res,
	output logic empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	res_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_res = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

FILE: rtl/pcsd_back.sv
// Back end: holds the configuration registers and drives the result register.
module pcsd_back
	import pcsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BUF_W-1:0]     cfg_data,
	input  logic                 empty,
	input  res_t                 pop_res,
	output logic                 pop,
	pcsd_out_if.source           res_out
);

	logic [DIM_W-1:0] canvas_w_q, canvas_h_q;
	logic [BUF_W-1:0] buf_bytes_q;
	logic             vld_q;
	kind_t            kind_q;
	logic [POS_W-1:0] x_q, y_q;
	logic [23:0]      rgb_q;
	logic [BUF_W-1:0] bufsz_q;
	logic             busy_q;

	assign pop = !empty && (!vld_q || res_out.ready);

	assign res_out.valid             = vld_q;
	assign res_out.kind              = 3'(kind_q);
	assign res_out.pos_x             = x_q;
	assign res_out.pos_y             = y_q;
	assign res_out.red               = rgb_q[23:16];
	assign res_out.green             = rgb_q[15:8];
	assign res_out.blue              = rgb_q[7:0];
	assign res_out.reply_buffer_size = bufsz_q;
	assign res_out.busy_res          = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_w_q  <= CANVAS_W_RST;
			canvas_h_q  <= CANVAS_H_RST;
			buf_bytes_q <= BUF_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CANVAS_W:  canvas_w_q  <= cfg_data[DIM_W-1:0];
				REG_CANVAS_H:  canvas_h_q  <= cfg_data[DIM_W-1:0];
				REG_BUF_BYTES: buf_bytes_q <= cfg_data;
				default:       buf_bytes_q <= buf_bytes_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop) begin
			vld_q <= 1'b1;
		end else if (res_out.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= pop_res.kind;
			rgb_q  <= pop_res.rgb;
			busy_q <= pop_res.busy;
			if (pop_res.kind == KIND_INFO) begin
				x_q     <= POS_W'(canvas_w_q);
				y_q     <= POS_W'(canvas_h_q);
				bufsz_q <= buf_bytes_q;
			end else begin
				x_q     <= pop_res.x;
				y_q     <= pop_res.y;
				bufsz_q <= '0;
			end
		end
	end

endmodule

FILE: rtl/pixel_command_stream_decoder.sv
// Top level of the pixel command stream decoder.
// cmd_in carries one item per handshake: func 0 delivers a received byte in
// data_byte, func 1 marks a send slot. res_out carries at most one result per
// item: pixel write, pixel read, info reply, refused byte, or an empty result
// that only reports busy_res. Items that cause no result produce nothing.
// The configuration port writes canvas width, canvas height and buffer size
// at index 0, 1 and 2 on any edge with cfg_we high; write only while idle.
// One item is accepted per cycle while the queue is not full. A result reaches
// res_out through the queue: the front end writes it into a four-entry queue
// as it accepts the item, and the back end pops it into the result register.
// When res_out stalls, the queue fills and cmd_in.ready drops once all four
// entries are taken; no item is lost.
// Reset clears the command assembly, both rectangles and the held flag,
// empties the queue and restores the register defaults 1920, 1080 and 65536.
module pixel_command_stream_decoder
	import pcsd_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int SIZE_BITS  = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pcsd_in_if.sink              cmd_in,
	pcsd_out_if.source           res_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BUF_W-1:0]     cfg_data
);

	logic push, full, pop, empty;
	res_t push_res, pop_res;

	pcsd_front #(
		.COORD_BITS (COORD_BITS),
		.SIZE_BITS  (SIZE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_in   (cmd_in),
		.full     (full),
		.push     (push),
		.push_res (push_res)
	);

	pcsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (push_res),
		.full     (full),
		.pop      (pop),
		.pop_res  (pop_res),
		.empty    (empty)
	);

	pcsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.empty     (empty),
		.pop_res   (pop_res),
		.pop       (pop),
		.res_out   (res_out)
	);

endmodule
